// ===== design/tcru_pkg.sv =====
package tcru_pkg;

    localparam logic [0:0] KIND_LOAD   = 1'b0;
    localparam logic [0:0] KIND_SAMPLE = 1'b1;

    localparam logic [1:0] CFG_EXPERT_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROUTE_COUNT  = 2'd1;

    localparam logic [4:0] EXPERT_COUNT_RST = 5'd16;
    localparam logic [2:0] ROUTE_COUNT_RST  = 3'd3;

    localparam logic signed [2:0] ELEM_MAX = 3'sd3;
    localparam logic signed [2:0] ELEM_MIN = -3'sd3;

    localparam int          DIST_OUT_MAX = 511;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_WR,
        ST_SCAN,
        ST_PICK_RD,
        ST_PICK_WR
    } tcru_state_t;

    typedef struct packed {
        logic       vld;
        logic [7:0] expert;
    } tcru_tag_t;

    function automatic logic signed [2:0] clamp_elem(input logic signed [31:0] v);
        logic signed [2:0] r;
        if (v > 32'sd3)
            r = ELEM_MAX;
        else if (v < -32'sd3)
            r = ELEM_MIN;
        else
            r = v[2:0];
        return r;
    endfunction

    function automatic logic [2:0] abs_diff(input logic signed [2:0] a,
                                            input logic signed [2:0] b);
        logic signed [3:0] d;
        d = 4'(a) - 4'(b);
        if (d < 4'sd0)
            d = -d;
        return d[2:0];
    endfunction

    function automatic logic signed [2:0] sat_add(input logic signed [2:0] a,
                                                  input logic signed [2:0] b);
        logic signed [3:0] s;
        logic signed [2:0] r;
        s = 4'(a) + 4'(b);
        if (s > 4'sd3)
            r = ELEM_MAX;
        else if (s < -4'sd3)
            r = ELEM_MIN;
        else
            r = s[2:0];
        return r;
    endfunction

endpackage

// ===== design/tcru_l1dist.sv =====
module tcru_l1dist #(
    parameter int VECTOR_DIM = 64,
    parameter int DW         = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [3*VECTOR_DIM-1:0]   row,
    input  logic [3*VECTOR_DIM-1:0]   samp,
    input  tcru_pkg::tcru_tag_t       tag_in,
    output logic [DW-1:0]             dist_out,
    output tcru_pkg::tcru_tag_t       tag_out
);

    localparam int NG  = (VECTOR_DIM + 7) / 8;
    localparam int PW  = NG * 8 * 3;
    localparam int GSW = 6;

    logic [PW-1:0]  row_pad;
    logic [PW-1:0]  samp_pad;
    logic [GSW-1:0] grp_next [NG];
    logic [GSW-1:0] grp_reg  [NG];
    logic [DW-1:0]  sum_next;
    logic [DW-1:0]  dist_reg;
    tcru_pkg::tcru_tag_t tag_a_reg;
    tcru_pkg::tcru_tag_t tag_b_reg;

    assign row_pad  = PW'(row);
    assign samp_pad = PW'(samp);

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < 8; j++)
            begin
                grp_next[g] = grp_next[g] + GSW'(tcru_pkg::abs_diff(
                    row_pad[(g*8+j)*3 +: 3], samp_pad[(g*8+j)*3 +: 3]));
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            sum_next = sum_next + DW'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg  <= grp_next;
        dist_reg <= sum_next;
    end

    assign dist_out = dist_reg;
    assign tag_out  = tag_b_reg;

endmodule

// ===== design/topk_centroid_router_update.sv =====
// Top-k nearest-centroid router with saturating centroid update.
// Input channel s_*: one transfer per element. s_tuser = 0 loads one centroid
// element into expert s_tdata[3:0]; s_tuser = 1 stores one sample element.
// s_tlast on a sample element starts routing of the gathered sample.
// Output channel m_*: one transfer per routed expert, in rank order; m_tlast
// marks the last one of a sample.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 expert
// count, 1 route count); write only while idle.
// Sequence: a sample element is stored directly; a centroid load reads, then
// writes back, one centroid row of the row memory. On the last sample element
// the block reads one centroid row per cycle over the experts in use, then
// waits for the distance pipeline (group sums, then total); each pick then
// reads the chosen row, and updates and writes it back.
// Reset: counts and sample clear at once; the centroid memory is cleared by a
// sweep over all MAX_EXPERTS rows, during which s_tready stays low.
// Stall: a result waits in the output register while m_tready is low; the
// next pick waits for it, and input is accepted again after the final pick.
module topk_centroid_router_update #(
    parameter int MAX_EXPERTS = 16,
    parameter int VECTOR_DIM  = 64,
    parameter int MAX_ROUTES  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // expert_index[3:0], element_index[9:4], value[41:10]
    input  logic        s_tuser,    // kind
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // chosen_expert[3:0], distance[12:4],
                                    // activation_total[44:13], rank[46:45]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_wdata
);

    localparam int EW    = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
    localparam int NW    = $clog2(MAX_EXPERTS + 1);
    localparam int VW    = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
    localparam int RIW   = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int RKW   = $clog2(MAX_ROUTES + 1);
    localparam int ROW_W = 3 * VECTOR_DIM;
    localparam int DW    = $clog2(6 * VECTOR_DIM + 1);

    tcru_pkg::tcru_state_t state_reg, state_next;

    logic [ROW_W-1:0] cent_mem [MAX_EXPERTS];
    logic [ROW_W-1:0] rd_row_reg;
    logic             mem_re;
    logic [EW-1:0]    mem_raddr;
    logic             mem_we;
    logic [EW-1:0]    mem_waddr;
    logic [ROW_W-1:0] mem_wdata;

    logic [4:0]       expert_count_reg;
    logic [2:0]       route_count_reg;
    logic [NW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [EW-1:0]    ld_ex_reg, ld_ex_next;
    logic [VW-1:0]    ld_el_reg, ld_el_next;
    logic [2:0]       ld_val_reg, ld_val_next;
    logic [ROW_W-1:0] samp_reg, samp_next;
    logic [NW-1:0]    scan_cnt_reg, scan_cnt_next;
    logic [NW-1:0]    done_cnt_reg, done_cnt_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [RKW-1:0]   k_reg, k_next;
    logic [RKW-1:0]   rank_reg, rank_next;
    logic [31:0]      cnt_reg [MAX_EXPERTS];

    logic [DW-1:0]    list_d_reg [MAX_ROUTES];
    logic [7:0]       list_e_reg [MAX_ROUTES];
    logic [MAX_ROUTES-1:0] list_v_reg;
    logic [DW-1:0]    list_d_next [MAX_ROUTES];
    logic [7:0]       list_e_next [MAX_ROUTES];
    logic [MAX_ROUTES-1:0] list_v_next;
    logic [MAX_ROUTES-1:0] lt;

    tcru_pkg::tcru_tag_t rd_tag_reg, rd_tag_next;
    tcru_pkg::tcru_tag_t dist_tag;
    logic [DW-1:0]       dist_val;

    logic             out_load;
    logic             m_tvalid_reg;
    logic [3:0]       out_chosen_reg, out_chosen_next;
    logic [8:0]       out_dist_reg, out_dist_next;
    logic [31:0]      out_act_reg, out_act_next;
    logic [1:0]       out_rank_reg, out_rank_next;
    logic             out_last_reg, out_last_next;
    logic             cnt_we;
    logic [EW-1:0]    cnt_idx;
    logic [31:0]      cnt_new;

    logic             in_acc;
    logic [3:0]       in_ex;
    logic [5:0]       in_el;
    logic signed [2:0] in_val;

    assign in_acc = s_tvalid && s_tready;
    assign in_ex  = s_tdata[3:0];
    assign in_el  = s_tdata[9:4];
    assign in_val = tcru_pkg::clamp_elem(s_tdata[41:10]);
    assign s_tready = (state_reg == tcru_pkg::ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cent_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_row_reg <= cent_mem[mem_raddr];
    end

    tcru_l1dist #(
        .VECTOR_DIM (VECTOR_DIM),
        .DW         (DW)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .row      (rd_row_reg),
        .samp     (samp_reg),
        .tag_in   (rd_tag_reg),
        .dist_out (dist_val),
        .tag_out  (dist_tag)
    );

    // insert each new distance into the sorted pick list; equal keeps order
    always_comb
    begin
        for (int i = 0; i < MAX_ROUTES; i++)
        begin
            lt[i] = !list_v_reg[i] || (dist_val < list_d_reg[i]);
        end
        list_d_next = list_d_reg;
        list_e_next = list_e_reg;
        list_v_next = list_v_reg;
        if (state_reg == tcru_pkg::ST_IDLE)
        begin
            list_v_next = '0;
        end
        else if (dist_tag.vld)
        begin
            if (lt[0])
            begin
                list_d_next[0] = dist_val;
                list_e_next[0] = dist_tag.expert;
                list_v_next[0] = 1'b1;
            end
            for (int i = 1; i < MAX_ROUTES; i++)
            begin
                if (lt[i] && lt[i-1])
                begin
                    list_d_next[i] = list_d_reg[i-1];
                    list_e_next[i] = list_e_reg[i-1];
                    list_v_next[i] = list_v_reg[i-1];
                end
                else if (lt[i])
                begin
                    list_d_next[i] = dist_val;
                    list_e_next[i] = dist_tag.expert;
                    list_v_next[i] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        int n_i;
        int k_i;
        logic [ROW_W-1:0] upd;
        n_i = (int'(expert_count_reg) > MAX_EXPERTS) ? MAX_EXPERTS : int'(expert_count_reg);
        k_i = (int'(route_count_reg) > MAX_ROUTES) ? MAX_ROUTES : int'(route_count_reg);
        if (k_i > n_i)
            k_i = n_i;
        upd = '0;

        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        ld_ex_next      = ld_ex_reg;
        ld_el_next      = ld_el_reg;
        ld_val_next     = ld_val_reg;
        samp_next       = samp_reg;
        scan_cnt_next   = scan_cnt_reg;
        done_cnt_next   = done_cnt_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        rank_next       = rank_reg;
        rd_tag_next     = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        out_load        = 1'b0;
        cnt_we          = 1'b0;
        cnt_idx         = list_e_reg[rank_reg[RIW-1:0]][EW-1:0];
        cnt_new         = (cnt_reg[cnt_idx] == tcru_pkg::COUNT_MAX) ?
                          cnt_reg[cnt_idx] : cnt_reg[cnt_idx] + 32'd1;
        out_chosen_next = list_e_reg[rank_reg[RIW-1:0]][3:0];
        out_dist_next   = (32'(list_d_reg[rank_reg[RIW-1:0]]) > 32'(tcru_pkg::DIST_OUT_MAX)) ?
                          9'(tcru_pkg::DIST_OUT_MAX) : 9'(list_d_reg[rank_reg[RIW-1:0]]);
        out_act_next    = cnt_new;
        out_rank_next   = 2'(rank_reg);
        out_last_next   = (32'(rank_reg) + 32'd1 == 32'(k_reg));

        if (dist_tag.vld)
            done_cnt_next = done_cnt_reg + NW'(1);

        unique case (state_reg)
            tcru_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg[EW-1:0];
                clr_cnt_next = clr_cnt_reg + NW'(1);
                if (32'(clr_cnt_reg) == 32'(MAX_EXPERTS - 1))
                    state_next = tcru_pkg::ST_IDLE;
            end
            tcru_pkg::ST_IDLE:
            begin
                if (in_acc && s_tuser == tcru_pkg::KIND_LOAD)
                begin
                    if (32'(in_ex) < 32'(MAX_EXPERTS) && 32'(in_el) < 32'(VECTOR_DIM))
                    begin
                        mem_re      = 1'b1;
                        mem_raddr   = EW'(in_ex);
                        ld_ex_next  = EW'(in_ex);
                        ld_el_next  = VW'(in_el);
                        ld_val_next = in_val;
                        state_next  = tcru_pkg::ST_LOAD_WR;
                    end
                end
                else if (in_acc)
                begin
                    if (32'(in_el) < 32'(VECTOR_DIM))
                        samp_next[VW'(in_el)*3 +: 3] = in_val;
                    if (s_tlast)
                    begin
                        n_next        = NW'(n_i);
                        k_next        = RKW'(k_i);
                        scan_cnt_next = '0;
                        done_cnt_next = '0;
                        rank_next     = '0;
                        if (k_i == 0)
                            samp_next = '0;
                        else
                            state_next = tcru_pkg::ST_SCAN;
                    end
                end
            end
            tcru_pkg::ST_LOAD_WR:
            begin
                upd = rd_row_reg;
                upd[ld_el_reg*3 +: 3] = ld_val_reg;
                mem_we     = 1'b1;
                mem_waddr  = ld_ex_reg;
                mem_wdata  = upd;
                state_next = tcru_pkg::ST_IDLE;
            end
            tcru_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg < n_reg)
                begin
                    mem_re             = 1'b1;
                    mem_raddr          = scan_cnt_reg[EW-1:0];
                    rd_tag_next.vld    = 1'b1;
                    rd_tag_next.expert = 8'(scan_cnt_reg);
                    scan_cnt_next      = scan_cnt_reg + NW'(1);
                end
                if (done_cnt_reg == n_reg)
                    state_next = tcru_pkg::ST_PICK_RD;
            end
            tcru_pkg::ST_PICK_RD:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = cnt_idx;
                    state_next = tcru_pkg::ST_PICK_WR;
                end
            end
            tcru_pkg::ST_PICK_WR:
            begin
                for (int i = 0; i < VECTOR_DIM; i++)
                begin
                    upd[i*3 +: 3] = tcru_pkg::sat_add(rd_row_reg[i*3 +: 3], samp_reg[i*3 +: 3]);
                end
                mem_we    = 1'b1;
                mem_waddr = cnt_idx;
                mem_wdata = upd;
                cnt_we    = 1'b1;
                out_load  = 1'b1;
                rank_next = rank_reg + RKW'(1);
                if (out_last_next)
                begin
                    samp_next  = '0;
                    state_next = tcru_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tcru_pkg::ST_PICK_RD;
                end
            end
            default:
            begin
                state_next = tcru_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tcru_pkg::ST_CLEAR;
            clr_cnt_reg      <= '0;
            samp_reg         <= '0;
            scan_cnt_reg     <= '0;
            done_cnt_reg     <= '0;
            n_reg            <= '0;
            k_reg            <= '0;
            rank_reg         <= '0;
            rd_tag_reg       <= '0;
            list_v_reg       <= '0;
            m_tvalid_reg     <= 1'b0;
            expert_count_reg <= tcru_pkg::EXPERT_COUNT_RST;
            route_count_reg  <= tcru_pkg::ROUTE_COUNT_RST;
            for (int i = 0; i < MAX_EXPERTS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            samp_reg     <= samp_next;
            scan_cnt_reg <= scan_cnt_next;
            done_cnt_reg <= done_cnt_next;
            n_reg        <= n_next;
            k_reg        <= k_next;
            rank_reg     <= rank_next;
            rd_tag_reg   <= rd_tag_next;
            list_v_reg   <= list_v_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cnt_we)
                cnt_reg[cnt_idx] <= cnt_new;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tcru_pkg::CFG_EXPERT_COUNT: expert_count_reg <= cfg_wdata;
                    tcru_pkg::CFG_ROUTE_COUNT:  route_count_reg  <= cfg_wdata[2:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ld_ex_reg  <= ld_ex_next;
        ld_el_reg  <= ld_el_next;
        ld_val_reg <= ld_val_next;
        list_d_reg <= list_d_next;
        list_e_reg <= list_e_next;
        if (out_load)
        begin
            out_chosen_reg <= out_chosen_next;
            out_dist_reg   <= out_dist_next;
            out_act_reg    <= out_act_next;
            out_rank_reg   <= out_rank_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_rank_reg, out_act_reg, out_dist_reg, out_chosen_reg};
    assign m_tlast  = out_last_reg;

    a_load_writes_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser == tcru_pkg::KIND_LOAD && 32'(in_ex) < 32'(MAX_EXPERTS)
         && 32'(in_el) < 32'(VECTOR_DIM)) |=> mem_we)
        else $error("centroid load not written back");

    a_pick_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcru_pkg::ST_PICK_RD && m_tvalid && !m_tready)
        |=> state_reg == tcru_pkg::ST_PICK_RD)
        else $error("pick advanced over held result");

    a_result_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == tcru_pkg::ST_PICK_WR)
        else $error("result raised outside pick update");

endmodule

// ===== test/tb_topk_centroid_router_update.sv =====
`timescale 1ns / 1ps

module tb_topk_centroid_router_update;

    localparam int EXPERTS   = 16;
    localparam int DIM       = 64;
    localparam int ROUTES    = 4;
    localparam int SETTLE    = 40;
    localparam int MAX_CYCLE = 300000;

    typedef struct {
        logic [3:0]  expert;
        logic [8:0]  dsum;
        logic [31:0] total;
        logic [1:0]  rank;
        logic        fin;
    } route_t;

    typedef struct {
        logic [0:0]  kind;
        logic [3:0]  ex;
        logic [5:0]  el;
        logic [31:0] value;
        logic        last;
        bit          typed;
        logic [3:0]  t_expert;
        logic [8:0]  t_dist;
    } elem_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_wdata;

    int          centroid [EXPERTS][DIM];
    logic [31:0] hits [EXPERTS];
    int          sample_vec [DIM];
    logic [4:0]  n_experts;
    logic [2:0]  n_routes;
    route_t      routes_due [$];
    int          errors;
    int          cycles;
    bit          quiet;

    topk_centroid_router_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int clamp3(logic [31:0] raw);
        int v;
        v = $signed(raw);
        if (v > 3)
            return 3;
        if (v < -3)
            return -3;
        return v;
    endfunction

    function automatic void route_elem(elem_t it);
        int  n;
        int  k;
        int  best;
        int  s;
        int  dsum_e [EXPERTS];
        bit  taken [EXPERTS];
        route_t r;
        if (it.kind == tcru_pkg::KIND_LOAD)
        begin
            centroid[it.ex][it.el] = clamp3(it.value);
            return;
        end
        sample_vec[it.el] = clamp3(it.value);
        if (!it.last)
            return;
        n = (n_experts > EXPERTS) ? EXPERTS : n_experts;
        k = (n_routes > ROUTES) ? ROUTES : n_routes;
        if (k > n)
            k = n;
        for (int e = 0; e < n; e++)
        begin
            dsum_e[e] = 0;
            taken[e] = 1'b0;
            for (int i = 0; i < DIM; i++)
                dsum_e[e] += (centroid[e][i] > sample_vec[i]) ?
                             centroid[e][i] - sample_vec[i] : sample_vec[i] - centroid[e][i];
        end
        for (int q = 0; q < k; q++)
        begin
            best = -1;
            for (int e = 0; e < n; e++)
                if (!taken[e] && (best < 0 || dsum_e[e] < dsum_e[best]))
                    best = e;
            taken[best] = 1'b1;
            if (hits[best] != 32'hFFFF_FFFF)
                hits[best] = hits[best] + 32'd1;
            for (int i = 0; i < DIM; i++)
            begin
                s = centroid[best][i] + sample_vec[i];
                centroid[best][i] = (s > 3) ? 3 : ((s < -3) ? -3 : s);
            end
            r.expert = 4'(best);
            r.dsum   = (dsum_e[best] > 511) ? 9'd511 : 9'(dsum_e[best]);
            r.total  = hits[best];
            r.rank   = 2'(q);
            r.fin    = (q + 1 == k);
            routes_due = {routes_due, r};
        end
        for (int i = 0; i < DIM; i++)
            sample_vec[i] = 0;
    endfunction

    task automatic send(elem_t it);
        int before_cnt;
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tlast  <= it.last;
        s_tdata  <= {6'd0, it.value, it.el, it.ex};
        do
            @(posedge clk);
        while (!s_tready);
        before_cnt = routes_due.size();
        route_elem(it);
        if (it.typed)
        begin
            if (routes_due.size() <= before_cnt)
            begin
                $display("%0t: expected expert %0d dist %0d, none predicted",
                         $time, it.t_expert, it.t_dist);
                errors++;
            end
            else if (routes_due[before_cnt].expert != it.t_expert ||
                     routes_due[before_cnt].dsum != it.t_dist)
            begin
                $display("%0t: expected expert %0d dist %0d, got expert %0d dist %0d",
                         $time, it.t_expert, it.t_dist,
                         routes_due[before_cnt].expert, routes_due[before_cnt].dsum);
                errors++;
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (routes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == tcru_pkg::CFG_EXPERT_COUNT)
            n_experts = val;
        else
            n_routes = val[2:0];
    endtask

    always @(negedge clk)
        m_tready <= quiet || ($urandom_range(0, 99) >= 25);

    always @(posedge clk)
    begin
        route_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (routes_due.size() == 0)
            begin
                $display("%0t: unexpected result %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = routes_due.pop_front();
                if (m_tdata[3:0] != want.expert)
                begin
                    $display("%0t: expert expected %0d actual %0d",
                             $time, want.expert, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[12:4] != want.dsum)
                begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, want.dsum, m_tdata[12:4]);
                    errors++;
                end
                if (m_tdata[44:13] != want.total)
                begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.total, m_tdata[44:13]);
                    errors++;
                end
                if (m_tdata[46:45] != want.rank)
                begin
                    $display("%0t: rank expected %0d actual %0d",
                             $time, want.rank, m_tdata[46:45]);
                    errors++;
                end
                if (m_tlast != want.fin)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, want.fin, m_tlast);
                    errors++;
                end
            end
        end
    end

    function automatic elem_t mk(logic [0:0] kind, int ex, int el, logic [31:0] value,
                                 logic last);
        elem_t it;
        it.kind  = kind;
        it.ex    = 4'(ex);
        it.el    = 6'(el);
        it.value = value;
        it.last  = last;
        it.typed = 1'b0;
        it.t_expert = '0;
        it.t_dist   = '0;
        return it;
    endfunction

    function automatic logic [31:0] rand_value();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, 8) - 4;
    endfunction

    initial
    begin
        elem_t directed [$];
        elem_t it;
        logic [4:0] ec_list [8];
        logic [2:0] rc_list [8];
        int run_len;
        int sent;

        ec_list   = '{5'd16, 5'd1, 5'd16, 5'd0, 5'd5, 5'd31, 5'd3, 5'd7};
        rc_list   = '{3'd3, 3'd1, 3'd4, 3'd2, 3'd0, 3'd7, 3'd4, 3'd2};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = tcru_pkg::CFG_EXPERT_COUNT;
        cfg_wdata = '0;
        errors    = 0;
        cycles    = 0;
        quiet     = 1'b0;
        n_experts = tcru_pkg::EXPERT_COUNT_RST;
        n_routes  = tcru_pkg::ROUTE_COUNT_RST;
        for (int e = 0; e < EXPERTS; e++)
        begin
            hits[e] = '0;
            for (int i = 0; i < DIM; i++)
                centroid[e][i] = 0;
        end
        for (int i = 0; i < DIM; i++)
            sample_vec[i] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all-zero store: nearest are the lowest indexes at distance zero
        it = mk(tcru_pkg::KIND_SAMPLE, 0, 0, 32'd0, 1'b1);
        it.typed = 1'b1;
        directed = {directed, it};
        directed = {directed, mk(tcru_pkg::KIND_LOAD, 0, 0, 32'h7FFF_FFFF, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_LOAD, 15, 63, 32'h8000_0000, 1'b1)};
        directed = {directed, mk(tcru_pkg::KIND_LOAD, 1, 5, -32'sd2, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_LOAD, 2, 10, 32'd2, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_LOAD, 3, 10, -32'sd1, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_LOAD, 3, 1, 32'd4, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 7, 0, 32'd3, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 0, 63, -32'sd3, 1'b1)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 15, 63, 32'd1000, 1'b1)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 15, 0, -32'sd1, 1'b1)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 0, 10, 32'd2, 1'b1)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 0, 33, 32'hFFFF_FFFC, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 0, 42, 32'hAAAA_AAAA, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 0, 21, 32'h5555_5555, 1'b1)};
        directed = {directed, mk(tcru_pkg::KIND_LOAD, 10, 42, 32'd3, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_LOAD, 10, 43, -32'sd3, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 0, 42, 32'd3, 1'b0)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 0, 43, -32'sd3, 1'b1)};
        directed = {directed, mk(tcru_pkg::KIND_SAMPLE, 0, 0, 32'd0, 1'b1)};

        foreach (directed[i])
            send(directed[i]);

        foreach (ec_list[p])
        begin
            write_reg(tcru_pkg::CFG_EXPERT_COUNT, ec_list[p]);
            write_reg(tcru_pkg::CFG_ROUTE_COUNT, {2'b00, rc_list[p]});
            quiet = (p == 2);
            sent = 0;
            while (sent < 30)
            begin
                if ($urandom_range(0, 99) < 30)
                begin
                    send(mk(tcru_pkg::KIND_LOAD, $urandom_range(0, 15), $urandom_range(0, 63),
                            rand_value(), 1'($urandom_range(0, 1))));
                    sent++;
                end
                else
                begin
                    run_len = $urandom_range(1, 5);
                    for (int j = 0; j < run_len; j++)
                    begin
                        it = mk(tcru_pkg::KIND_SAMPLE, $urandom_range(0, 15),
                                $urandom_range(0, 63), rand_value(), j == run_len - 1);
                        // occasionally break the run off without a last mark
                        if (j == run_len - 1 && $urandom_range(0, 9) == 0)
                            it.last = 1'b0;
                        send(it);
                        sent++;
                    end
                end
            end
        end
        quiet = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (routes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tcru_pkg.sv
design/tcru_l1dist.sv
design/topk_centroid_router_update.sv
test/tb_topk_centroid_router_update.sv
